// File: rtl/core/sfpt_pkg.sv
package sfpt_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int SYM_W  = 8;
    localparam int WGT_W  = 16;
    localparam int AGE_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 9;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - OCC_W - WGT_W - SYM_W;

    localparam logic [CMD_W-1:0] CMD_COUNT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [WGT_W-1:0] cnt;
        logic [AGE_W-1:0] age;
    } t_entry;

endpackage

// File: rtl/core/symbol_frequency_priority_table.sv
// Channel   | Direction | tdata (low bit up)                          | tuser
// s_axis    | in        | symbol[7:0], weight[23:8]                   | command[1:0]
// m_axis    | out       | out_symbol[7:0], out_count[23:8],           | status[1:0]
//           |           | occupancy[32:24], zero[39:33]               |
//
// Count and extract scan the held entries one per cycle through the single read
// port of the entry memory, then pass ST_EVAL; a count that finds its symbol
// ends in ST_DONE, one that adds an entry passes ST_ADD, extract ST_FETCH first.
// Insert, count on an empty table: ST_ADD; extract on empty, unused command: ST_DONE.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A new transfer is taken while a finished result still waits on m_axis; a
// stalled m_axis holds the next result in the last step of its command.
module symbol_frequency_priority_table
    import sfpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // symbol, weight
    input  logic [CMD_W-1:0]     s_axis_tuser,   // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // out_symbol, out_count, occupancy
    output logic [STAT_W-1:0]    m_axis_tuser    // status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    t_entry mem [ENTRIES];

    logic [2:0]           r_state,     n_state;
    logic [CMD_W-1:0]     r_cmd,       n_cmd;
    logic [SYM_W-1:0]     r_sym,       n_sym;
    logic [WGT_W-1:0]     r_wgt,       n_wgt;
    logic [CNT_W-1:0]     r_held,      n_held;
    logic [AGE_W-1:0]     r_stamp,     n_stamp;
    logic [CNT_W-1:0]     r_issue,     n_issue;
    logic                 r_rd_valid,  n_rd_valid;
    logic [IDX_W-1:0]     r_rd_idx,    n_rd_idx;
    logic                 r_found,     n_found;
    t_entry               r_best,      n_best;
    logic [IDX_W-1:0]     r_best_idx,  n_best_idx;
    logic [AGE_W-1:0]     r_best_rec,  n_best_rec;
    logic [SYM_W-1:0]     r_res_sym,   n_res_sym;
    logic [WGT_W-1:0]     r_res_cnt,   n_res_cnt;
    logic [STAT_W-1:0]    r_res_stat,  n_res_stat;
    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data,  n_out_data;
    logic [STAT_W-1:0]    r_out_user,  n_out_user;
    t_entry               r_rd_data;

    logic                 s_accept;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     w_addr;
    t_entry               w_data;
    logic [CNT_W-1:0]     last;
    logic [AGE_W-1:0]     rec;
    logic                 take;
    logic [WGT_W-1:0]     inc_cnt;
    logic                 full;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    assign last    = r_held - CNT_W'(1);
    assign full    = (r_held == CNT_W'(ENTRIES));
    assign rec     = r_stamp - AGE_W'(1) - r_rd_data.age;
    assign inc_cnt = (r_best.cnt == '1) ? r_best.cnt : r_best.cnt + WGT_W'(1);

    always_comb begin
        if (r_cmd == CMD_COUNT) begin
            take = (r_rd_data.sym == r_sym) && (!r_found || rec < r_best_rec);
        end else begin
            take = !r_found || (r_rd_data.cnt < r_best.cnt) ||
                   ((r_rd_data.cnt == r_best.cnt) && (rec < r_best_rec));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_sym       = r_sym;
        n_wgt       = r_wgt;
        n_held      = r_held;
        n_stamp     = r_stamp;
        n_issue     = r_issue;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_rec  = r_best_rec;
        n_res_sym   = r_res_sym;
        n_res_cnt   = r_res_cnt;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        rd_addr     = r_issue[IDX_W-1:0];
        mem_we      = 1'b0;
        w_addr      = r_best_idx;
        w_data      = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_cmd   = s_axis_tuser;
                    n_sym   = s_axis_tdata[SYM_W-1:0];
                    n_wgt   = s_axis_tdata[SYM_W+WGT_W-1:SYM_W];
                    n_found = 1'b0;
                    n_issue = '0;
                    case (s_axis_tuser)
                        CMD_COUNT: begin
                            n_state = (r_held == '0) ? ST_ADD : ST_SCAN;
                        end
                        CMD_INSERT: begin
                            n_state = ST_ADD;
                        end
                        CMD_EXTRACT: begin
                            if (r_held == '0) begin
                                n_res_sym  = '0;
                                n_res_cnt  = '0;
                                n_res_stat = STAT_EMPTY;
                                n_state    = ST_DONE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_res_sym  = '0;
                            n_res_cnt  = '0;
                            n_res_stat = STAT_OK;
                            n_state    = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_issue < r_held) begin
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_issue[IDX_W-1:0];
                    n_issue    = r_issue + CNT_W'(1);
                end
                if (r_rd_valid) begin
                    if (take) begin
                        n_found    = 1'b1;
                        n_best     = r_rd_data;
                        n_best_idx = r_rd_idx;
                        n_best_rec = rec;
                    end
                    if (CNT_W'(r_rd_idx) == last) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                rd_addr = last[IDX_W-1:0];
                if (r_cmd == CMD_COUNT) begin
                    if (r_found) begin
                        mem_we     = 1'b1;
                        w_addr     = r_best_idx;
                        w_data     = '{sym: r_best.sym, cnt: inc_cnt, age: r_best.age};
                        n_res_sym  = r_sym;
                        n_res_cnt  = inc_cnt;
                        n_res_stat = STAT_OK;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_ADD;
                    end
                end else begin
                    n_res_sym  = r_best.sym;
                    n_res_cnt  = r_best.cnt;
                    n_res_stat = STAT_OK;
                    n_state    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // last entry fills the freed slot
                mem_we  = 1'b1;
                w_addr  = r_best_idx;
                w_data  = r_rd_data;
                n_held  = last;
                n_state = ST_DONE;
            end
            ST_ADD: begin
                n_res_sym = r_sym;
                if (full) begin
                    n_res_cnt  = '0;
                    n_res_stat = STAT_FULL;
                end else begin
                    mem_we     = 1'b1;
                    w_addr     = r_held[IDX_W-1:0];
                    w_data     = '{sym: r_sym,
                                   cnt: (r_cmd == CMD_COUNT) ? WGT_W'(1) : r_wgt,
                                   age: r_stamp};
                    n_stamp    = r_stamp + AGE_W'(1);
                    n_held     = r_held + CNT_W'(1);
                    n_res_cnt  = (r_cmd == CMD_COUNT) ? WGT_W'(1) : r_wgt;
                    n_res_stat = STAT_OK;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {M_PAD_W'(0), OCC_W'(r_held), r_res_cnt, r_res_sym};
                    n_out_user  = r_res_stat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_stamp     <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_stamp     <= n_stamp;
            r_rd_valid  <= n_rd_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_sym      <= n_sym;
        r_wgt      <= n_wgt;
        r_issue    <= n_issue;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_rec <= n_best_rec;
        r_res_sym  <= n_res_sym;
        r_res_cnt  <= n_res_cnt;
        r_res_stat <= n_res_stat;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state != ST_IDLE)
        else $error("accepted transfer did not start a command");

    a_rd_valid_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> r_state == ST_SCAN)
        else $error("scan read returned outside the scan");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> CNT_W'(w_addr) <= r_held && r_held <= CNT_W'(ENTRIES))
        else $error("entry write beyond held entries");

    a_held_changes_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != $past(r_held) |-> r_state == ST_DONE)
        else $error("entry count changed outside add or removal");

endmodule
